>>> design/sphere_deform_tile_frame_defines.svh
// assertion macros for the tile frame block
`ifndef SPHERE_DEFORM_TILE_FRAME_DEFINES_SVH
`define SPHERE_DEFORM_TILE_FRAME_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SDT_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sphere_deform_tile_frame: check failed");
// next-cycle implication
`define SDT_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sphere_deform_tile_frame: check failed");
`else
`define SDT_ASSERT_IMP(label, clk, rst, ante, cons)
`define SDT_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

>>> design/sdt_pkg.sv
`default_nettype none
package sdt_pkg;

  // square root datapath: radicand is a 64 bit sum shifted up by 60
  localparam int SQ_W = 124;
  localparam int RT_W = 62;

  // divider datapath
  localparam int DIV_NUM_W = 152;
  localparam int DIV_DEN_W = 126;
  localparam int DIV_REM_W = DIV_DEN_W + 32;
  localparam int DIV_STEPS = 31;
  localparam int DIV_LAT   = DIV_STEPS + 1;

  typedef logic [SQ_W-1:0]      sq_t;
  typedef logic [RT_W-1:0]      rt_t;
  typedef logic [DIV_NUM_W-1:0] div_num_t;
  typedef logic [DIV_DEN_W-1:0] div_den_t;
  typedef logic [DIV_REM_W-1:0] div_rem_t;
  typedef logic [31:0]          mag_t;
  typedef logic signed [31:0]   term_t;

  localparam mag_t MAG_CAP = 32'h8000_0000;
  localparam term_t TERM_MAX = 32'sh7FFF_FFFF;
  localparam logic [30:0] ROOT_QUAD_RESET = 31'd65536;

  typedef enum logic [0:0] {
    REG_DEFORM_ENABLE  = 1'b0,
    REG_ROOT_QUAD_SIZE = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic signed [31:0] tile_origin_x;
    logic signed [31:0] tile_origin_y;
    logic [30:0]        tile_length;
  } in_t;

  typedef struct packed {
    logic  deformed;
    term_t normal_x_a;
    term_t normal_x_b;
    term_t normal_y_a;
    term_t normal_y_b;
    term_t local_x_a;
    term_t local_x_b;
    term_t local_y_a;
    term_t local_y_b;
  } out_t;

  // per-item values carried alongside the root pipeline
  typedef struct packed {
    logic        valid;
    logic        en;
    logic        nxy;
    logic [30:0] s;
    logic [61:0] s2;
    logic [61:0] xy;
    logic [62:0] p;
    logic [62:0] u;
    logic [63:0] t;
  } side_t;

  // what survives past the dividers
  typedef struct packed {
    logic valid;
    logic en;
    logic nxy;
  } tail_t;

endpackage
`default_nettype wire

>>> design/sphere_deform_tile_frame.sv
`default_nettype none
`include "sphere_deform_tile_frame_defines.svh"
// spherical deformation frame terms for one terrain tile
// request channel: an item (tile origin x, y and edge length) is taken at a
//   rising edge with start high; busy is always low, so one item per cycle
// result channel: done is high for one cycle with the eight q3.29 terms and
//   the deformed flag on result; the receiver cannot hold results off and
//   none is needed, as the pipeline never stalls
// throughput one item per cycle; the pipeline depth comes from two 62-step root
//   pipelines (one bit per stage), a two-stage split multiplier and six
//   32-stage restoring dividers
// configuration: apb-style, register 0 deform_enable at 0x0, register 1
//   root_quad_size at 0x4; write only with no item in flight
// reset: synchronous, clears all valid bits and loads enable 1 and root
//   size 65536; results are only ever shown for accepted items
module sphere_deform_tile_frame (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  sdt_pkg::in_t   request,
  output logic           done,
  output sdt_pkg::out_t  result,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

  localparam int RtW    = sdt_pkg::RT_W;
  localparam int DivLat = sdt_pkg::DIV_LAT;
  localparam int NMul   = 5;

  // configuration registers
  logic        deform_enable;
  logic [30:0] root_quad_size;

  assign pready = 1'b1;
  assign busy   = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      deform_enable  <= 1'b1;
      root_quad_size <= sdt_pkg::ROOT_QUAD_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (sdt_pkg::reg_idx_t'(paddr[2]))
        sdt_pkg::REG_DEFORM_ENABLE:  deform_enable  <= pwdata[0];
        sdt_pkg::REG_ROOT_QUAD_SIZE: root_quad_size <= pwdata[30:0];
      endcase
    end
  end

  always_comb begin
    unique case (sdt_pkg::reg_idx_t'(paddr[2]))
      sdt_pkg::REG_DEFORM_ENABLE:  prdata = {31'b0, deform_enable};
      sdt_pkg::REG_ROOT_QUAD_SIZE: prdata = {1'b0, root_quad_size};
    endcase
  end

  // stage 1: doubled centre, X = 2*ox + l, Y = 2*oy + l
  logic               st1_valid, st1_en;
  logic signed [33:0] st1_x, st1_y;
  logic [30:0]        st1_s;

  always_ff @(posedge clk) begin
    st1_valid <= rst ? 1'b0 : start && !busy;
    st1_en    <= deform_enable;
    st1_s     <= root_quad_size;
    st1_x     <= ($signed({{2{request.tile_origin_x[31]}}, request.tile_origin_x}) <<< 1) +
                 $signed({3'b0, request.tile_length});
    st1_y     <= ($signed({{2{request.tile_origin_y[31]}}, request.tile_origin_y}) <<< 1) +
                 $signed({3'b0, request.tile_length});
  end

  // stage 2: magnitudes and product sign
  logic        st2_valid, st2_en, st2_nxy;
  logic [32:0] st2_mx, st2_my;
  logic [30:0] st2_s;
  logic [33:0] neg_x, neg_y;

  assign neg_x = -st1_x;
  assign neg_y = -st1_y;

  always_ff @(posedge clk) begin
    st2_valid <= rst ? 1'b0 : st1_valid;
    st2_en    <= st1_en;
    st2_s     <= st1_s;
    st2_nxy   <= st1_x[33] != st1_y[33];
    st2_mx    <= st1_x[33] ? neg_x[32:0] : st1_x[32:0];
    st2_my    <= st1_y[33] ? neg_y[32:0] : st1_y[32:0];
  end

  // stage 3: common right shift until all three fit in 31 bits
  logic        st3_valid, st3_en, st3_nxy;
  logic [30:0] st3_mx, st3_my, st3_s;
  logic [32:0] any_bits;
  logic [32:0] sh_mx, sh_my, sh_s;

  assign any_bits = st2_mx | st2_my | {2'b0, st2_s};

  always_comb begin
    if (any_bits[32]) begin
      sh_mx = st2_mx >> 2;
      sh_my = st2_my >> 2;
      sh_s  = {2'b0, st2_s} >> 2;
    end else if (any_bits[31]) begin
      sh_mx = st2_mx >> 1;
      sh_my = st2_my >> 1;
      sh_s  = {2'b0, st2_s} >> 1;
    end else begin
      sh_mx = st2_mx;
      sh_my = st2_my;
      sh_s  = {2'b0, st2_s};
    end
  end

  always_ff @(posedge clk) begin
    st3_valid <= rst ? 1'b0 : st2_valid;
    st3_en    <= st2_en;
    st3_mx    <= sh_mx[30:0];
    st3_my    <= sh_my[30:0];
    st3_s     <= sh_s[30:0];
    st3_nxy   <= st2_nxy && (sh_mx != '0) && (sh_my != '0);
  end

  // stage 4: squares and cross product
  logic        st4_valid, st4_en, st4_nxy;
  logic [30:0] st4_s;
  logic [61:0] st4_mx2, st4_my2, st4_s2, st4_xy;

  always_ff @(posedge clk) begin
    st4_valid <= rst ? 1'b0 : st3_valid;
    st4_en    <= st3_en;
    st4_nxy   <= st3_nxy;
    st4_s     <= st3_s;
    st4_mx2   <= st3_mx * st3_mx;
    st4_my2   <= st3_my * st3_my;
    st4_s2    <= st3_s * st3_s;
    st4_xy    <= st3_mx * st3_my;
  end

  // stage 5 feeds the root pipelines: P, U and T
  sdt_pkg::side_t side   [0:RtW];
  sdt_pkg::sq_t   rt_rem [0:RtW];
  sdt_pkg::rt_t   rt_res [0:RtW];
  sdt_pkg::sq_t   rp_rem [0:RtW];
  sdt_pkg::rt_t   rp_res [0:RtW];
  logic [62:0]    sum_p;
  logic [63:0]    sum_t;

  assign sum_p = 63'(st4_my2) + 63'(st4_s2);
  assign sum_t = 64'(st4_mx2) + 64'(sum_p);

  always_ff @(posedge clk) begin
    side[0].valid <= rst ? 1'b0 : st4_valid;
    side[0].en    <= st4_en;
    side[0].nxy   <= st4_nxy;
    side[0].s     <= st4_s;
    side[0].s2    <= st4_s2;
    side[0].xy    <= st4_xy;
    side[0].p     <= sum_p;
    side[0].u     <= 63'(st4_mx2) + 63'(st4_s2);
    side[0].t     <= sum_t;
    rt_rem[0] <= {sum_t, 60'b0};
    rp_rem[0] <= {1'b0, sum_p, 60'b0};
    rt_res[0] <= '0;
    rp_res[0] <= '0;
  end

  // digit-by-digit roots, one result bit per stage, msb first
  for (genvar g = 1; g <= RtW; g++) begin : g_root
    localparam int B = RtW - g;
    sdt_pkg::sq_t rt_trial, rp_trial;
    logic         rt_take, rp_take;
    assign rt_trial = (sdt_pkg::sq_t'(rt_res[g-1]) << (B + 1)) | (sdt_pkg::sq_t'(1) << (2 * B));
    assign rp_trial = (sdt_pkg::sq_t'(rp_res[g-1]) << (B + 1)) | (sdt_pkg::sq_t'(1) << (2 * B));
    assign rt_take  = rt_rem[g-1] >= rt_trial;
    assign rp_take  = rp_rem[g-1] >= rp_trial;
    always_ff @(posedge clk) begin
      rt_rem[g] <= rt_take ? rt_rem[g-1] - rt_trial : rt_rem[g-1];
      rp_rem[g] <= rp_take ? rp_rem[g-1] - rp_trial : rp_rem[g-1];
      rt_res[g] <= rt_res[g-1] | (sdt_pkg::rt_t'(rt_take) << B);
      rp_res[g] <= rp_res[g-1] | (sdt_pkg::rt_t'(rp_take) << B);
      if (rst) begin
        side[g].valid <= 1'b0;
      end else begin
        side[g] <= side[g-1];
      end
    end
  end

  // split multipliers: 32x32 partial products, then one sum
  logic [63:0]    mop_a [0:NMul-1];
  logic [63:0]    mop_b [0:NMul-1];
  logic [63:0]    pp00  [0:NMul-1];
  logic [63:0]    pp01  [0:NMul-1];
  logic [63:0]    pp10  [0:NMul-1];
  logic [63:0]    pp11  [0:NMul-1];
  logic [127:0]   prod  [0:NMul-1];
  sdt_pkg::side_t side_m1, side_m2;

  always_comb begin
    // S*Rt, S*Rp, Rp*T, Rp*Rt, S*XY
    mop_a[0] = 64'(side[RtW].s);
    mop_b[0] = 64'(rt_res[RtW]);
    mop_a[1] = 64'(side[RtW].s);
    mop_b[1] = 64'(rp_res[RtW]);
    mop_a[2] = 64'(rp_res[RtW]);
    mop_b[2] = side[RtW].t;
    mop_a[3] = 64'(rp_res[RtW]);
    mop_b[3] = 64'(rt_res[RtW]);
    mop_a[4] = 64'(side[RtW].s);
    mop_b[4] = 64'(side[RtW].xy);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NMul; i++) begin
      pp00[i] <= mop_a[i][31:0]  * mop_b[i][31:0];
      pp01[i] <= mop_a[i][31:0]  * mop_b[i][63:32];
      pp10[i] <= mop_a[i][63:32] * mop_b[i][31:0];
      pp11[i] <= mop_a[i][63:32] * mop_b[i][63:32];
      prod[i] <= (128'(pp11[i]) << 64) + (128'(pp01[i]) << 32) +
                 (128'(pp10[i]) << 32) + 128'(pp00[i]);
    end
    if (rst) begin
      side_m1.valid <= 1'b0;
      side_m2.valid <= 1'b0;
    end else begin
      side_m1 <= side[RtW];
      side_m2 <= side_m1;
    end
  end

  // six quotients; the x*y/d term serves both signs
  sdt_pkg::div_num_t num [0:5];
  sdt_pkg::div_den_t den [0:5];
  sdt_pkg::mag_t     mag [0:5];

  always_comb begin
    num[0] = sdt_pkg::div_num_t'({side_m2.xy, 59'b0});
    den[0] = sdt_pkg::div_den_t'(prod[0]);
    num[1] = sdt_pkg::div_num_t'({side_m2.p, 59'b0});
    den[1] = sdt_pkg::div_den_t'(prod[0]);
    num[2] = sdt_pkg::div_num_t'({side_m2.u, 59'b0});
    den[2] = sdt_pkg::div_den_t'(prod[0]);
    num[3] = sdt_pkg::div_num_t'(prod[1]);
    den[3] = sdt_pkg::div_den_t'({side_m2.t, 1'b0});
    num[4] = {prod[4][92:0], 59'b0};
    den[4] = sdt_pkg::div_den_t'(prod[2]);
    num[5] = sdt_pkg::div_num_t'({side_m2.s2, 89'b0});
    den[5] = sdt_pkg::div_den_t'(prod[3]);
  end

  for (genvar d = 0; d < 6; d++) begin : g_div
    sdt_divider u_div (
      .clk (clk),
      .num (num[d]),
      .den (den[d]),
      .mag (mag[d])
    );
  end

  // control bits ride alongside the dividers
  sdt_pkg::tail_t tail [1:DivLat];

  always_ff @(posedge clk) begin
    tail[1].valid <= rst ? 1'b0 : side_m2.valid;
    tail[1].en    <= side_m2.en;
    tail[1].nxy   <= side_m2.nxy;
    for (int k = 2; k <= DivLat; k++) begin
      if (rst) begin
        tail[k].valid <= 1'b0;
      end else begin
        tail[k] <= tail[k-1];
      end
    end
  end

  // sign and saturate a magnitude of at most 2^31
  function automatic sdt_pkg::term_t enc(input sdt_pkg::mag_t m, input logic neg);
    sdt_pkg::mag_t twos;
    twos = ~m + 32'd1;
    if (neg) return sdt_pkg::term_t'(twos);
    if (m[31]) return sdt_pkg::TERM_MAX;
    return sdt_pkg::term_t'(m);
  endfunction

  sdt_pkg::out_t result_next;
  logic          fin_nxy;

  assign fin_nxy = tail[DivLat].nxy;

  always_comb begin
    result_next = '0;
    if (tail[DivLat].en) begin
      result_next.deformed   = 1'b1;
      result_next.normal_x_a = enc(mag[0], fin_nxy);
      result_next.normal_x_b = enc(mag[1], 1'b0);
      result_next.normal_y_a = enc(mag[2], 1'b1);
      result_next.normal_y_b = enc(mag[0], !fin_nxy && (mag[0] != '0));
      result_next.local_x_a  = enc(mag[3], 1'b0);
      result_next.local_y_a  = enc(mag[4], !fin_nxy && (mag[4] != '0));
      result_next.local_y_b  = enc(mag[5], 1'b0);
    end
  end

  always_ff @(posedge clk) begin
    done   <= rst ? 1'b0 : tail[DivLat].valid;
    result <= result_next;
  end

  // any term field of the shown result that carries a value
  logic any_term;

  assign any_term = |{result.normal_x_a, result.normal_x_b, result.normal_y_a,
                      result.normal_y_b, result.local_x_a, result.local_y_a,
                      result.local_y_b};

  // an accepted item is in the first stage in the next cycle
  `SDT_ASSERT_NXT(a_accept_enters, clk, rst, start && !busy, st1_valid)
  // a disabled result carries only zero terms
  `SDT_ASSERT_IMP(a_disabled_zero, clk, rst, done && !result.deformed, !any_term)
  // the second local x term never carries a value
  `SDT_ASSERT_IMP(a_lxb_zero, clk, rst, done, result.local_x_b == '0)
  // the first normal y term is never positive
  `SDT_ASSERT_IMP(a_nya_sign, clk, rst, done && result.deformed, result.normal_y_a[31] || (result.normal_y_a == '0))

endmodule
`default_nettype wire

>>> design/sdt_divider.sv
`default_nettype none
module sdt_divider (
  input  logic               clk,
  input  sdt_pkg::div_num_t  num,
  input  sdt_pkg::div_den_t  den,
  output sdt_pkg::mag_t      mag
);

  localparam int Steps = sdt_pkg::DIV_STEPS;

  sdt_pkg::div_num_t rem [0:Steps];
  sdt_pkg::div_den_t dd  [0:Steps];
  logic [Steps-1:0]  q   [0:Steps];
  logic              cap [0:Steps];

  // saturation is known up front: quotient would reach the cap
  always_ff @(posedge clk) begin
    rem[0] <= num;
    dd[0]  <= den;
    q[0]   <= '0;
    cap[0] <= (sdt_pkg::div_rem_t'(num) >= (sdt_pkg::div_rem_t'(den) << Steps)) &&
              (num != '0);
  end

  for (genvar k = 1; k <= Steps; k++) begin : g_step
    localparam int J = Steps - k;
    sdt_pkg::div_rem_t trial;
    logic              take;
    assign trial = sdt_pkg::div_rem_t'(dd[k-1]) << J;
    // a zero divisor never takes a bit, so zero over zero stays zero
    assign take  = (dd[k-1] != '0) && (sdt_pkg::div_rem_t'(rem[k-1]) >= trial);
    always_ff @(posedge clk) begin
      rem[k] <= take ? sdt_pkg::div_num_t'(sdt_pkg::div_rem_t'(rem[k-1]) - trial)
                     : rem[k-1];
      q[k]   <= q[k-1] | ({{(Steps-1){1'b0}}, take} << J);
      dd[k]  <= dd[k-1];
      cap[k] <= cap[k-1];
    end
  end

  assign mag = cap[Steps] ? sdt_pkg::MAG_CAP : {1'b0, q[Steps]};

endmodule
`default_nettype wire
